### rtl/cpc_pkg.sv
// Shared types and constants for the current peak counter.
// Holds sample types, fixed-point thresholds and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

    typedef logic [11:0] t_centi;
    typedef logic [1:0]  t_run;
    typedef logic [1:0]  t_cfg_idx;

    localparam t_run        RUN_SAT        = 2'd3;
    localparam t_centi      FALLBACK_LEVEL = 12'd550;
    localparam logic [12:0] SPAN_LIMIT     = 13'd150;
    localparam t_centi      MIN_RESET      = 12'd1000;
    localparam logic [31:0] TIMEOUT_RESET  = 32'd60000;

    localparam t_cfg_idx CFG_IDX_ENABLE  = 2'd0;
    localparam t_cfg_idx CFG_IDX_TIMEOUT = 2'd1;

endpackage

`default_nettype wire

### rtl/current_peak_counter_core.sv
// Top level of the current peak counter: input stage, peak detection state and result.
// Depends on cpc_pkg for types, thresholds and register indexes.
`timescale 1ns / 1ps
`default_nettype none

// Adaptive-threshold peak counter for motor current samples.
//
// Input channel: i_in_valid / o_in_stall carry one sample (centiamps) and a
// millisecond timestamp per transfer. Output channel: o_out_valid /
// i_out_stall carry one result per input transfer: peak count, arm flag,
// inactivity flag, time between the last two peaks, threshold, min and max.
// Configuration channel: i_cfg_valid / o_cfg_ready with a register index
// (0 = inactivity enable, 1 = idle timeout in ms); other indexes are dropped.
// Write configuration only while no sample is in flight.
//
// A transferred sample is registered in the input stage and then moves into the
// result register once the result is free or taken. Throughput: one sample per
// cycle unless the receiver stalls; the update is one pass of compares, 13-bit
// adds and 32-bit subtracts. When the receiver stalls, the result holds and the
// input stage holds one more sample; o_in_stall rises only when both are full.
// Reset (synchronous, active low) empties both stages, restores the min to
// 10.00 A, the max to zero, the threshold to 5.50 A, and all counters to zero.
module current_peak_counter_core
    import cpc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // sample channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [11:0] i_sample_centiamps,
    input  wire logic [31:0] i_now_ms,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_peak_total,
    output logic             o_edge_armed,
    output logic             o_idle_flag,
    output logic [31:0]      o_peak_interval_ms,
    output logic [11:0]      o_level_centiamps,
    output logic [11:0]      o_low_centiamps,
    output logic [11:0]      o_high_centiamps,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire t_cfg_idx    i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // configuration registers
    logic        r_idle_en;
    logic [31:0] r_idle_timeout;

    // input stage
    logic        r_s1_valid;
    t_centi      r_s1_sample;
    logic [31:0] r_s1_now;

    // detector state; these registers also serve as the result register
    logic                   r_out_valid;
    t_centi                 r_prior;
    t_run                   r_rise_run;
    t_run                   r_fall_run;
    logic                   r_armed;
    logic [COUNT_WIDTH-1:0] r_peaks;
    t_centi                 r_min;
    t_centi                 r_max;
    t_centi                 r_level;
    logic [COUNT_WIDTH-1:0] r_idle_seen;
    logic [31:0]            r_idle_start;
    logic                   r_idle_state;
    logic [COUNT_WIDTH-1:0] r_lap_seen;
    logic [31:0]            r_lap_start;
    logic [31:0]            r_lap_interval;

    // next values
    t_run                   n_rise_run;
    t_run                   n_fall_run;
    logic                   n_armed;
    logic [COUNT_WIDTH-1:0] n_peaks;
    t_centi                 n_min;
    t_centi                 n_max;
    t_centi                 n_level;
    logic [COUNT_WIDTH-1:0] n_idle_seen;
    logic [31:0]            n_idle_start;
    logic                   n_idle_state;
    logic [COUNT_WIDTH-1:0] n_lap_seen;
    logic [31:0]            n_lap_start;
    logic [31:0]            n_lap_interval;

    logic        w_s1_adv;
    logic        w_in_xfer;
    logic [12:0] w_sum;
    logic [31:0] w_peaks_ext;

    // Advance the input stage into the result when the result is free or taken.
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_adv;
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_rise_run = r_rise_run;
        n_fall_run = r_fall_run;
        n_armed    = r_armed;
        n_peaks    = r_peaks;

        if (r_s1_sample > r_prior) begin
            if (r_rise_run < RUN_SAT) begin
                n_rise_run = r_rise_run + 2'd1;
            end
            n_fall_run = '0;
            // arm against the threshold from before this sample
            if (n_rise_run == RUN_SAT && !r_armed && r_s1_sample >= r_level) begin
                n_armed = 1'b1;
            end
        end else begin
            if (r_fall_run < RUN_SAT) begin
                n_fall_run = r_fall_run + 2'd1;
            end
            n_rise_run = '0;
            if (n_fall_run == RUN_SAT && r_armed && r_s1_sample <= r_level) begin
                n_peaks = r_peaks + COUNT_WIDTH'(1);
                n_armed = 1'b0;
            end
        end

        n_min = (r_s1_sample < r_min) ? r_s1_sample : r_min;
        n_max = (r_s1_sample > r_max) ? r_s1_sample : r_max;
        w_sum = {1'b0, n_max} + {1'b0, n_min};
        // narrow swing: fall back to the fixed 5.50 A threshold
        if ({1'b0, n_max} <= {1'b0, n_min} + SPAN_LIMIT) begin
            n_level = FALLBACK_LEVEL;
        end else begin
            n_level = w_sum[12:1];
        end

        n_idle_seen  = r_idle_seen;
        n_idle_start = r_idle_start;
        n_idle_state = r_idle_state;
        if (r_idle_en) begin
            if (n_peaks != r_idle_seen) begin
                n_idle_start = r_s1_now;
                n_idle_seen  = n_peaks;
            end
            n_idle_state = ((r_s1_now - n_idle_start) >= r_idle_timeout);
        end

        n_lap_seen     = r_lap_seen;
        n_lap_start    = r_lap_start;
        n_lap_interval = r_lap_interval;
        if (n_peaks != r_lap_seen) begin
            n_lap_interval = r_s1_now - r_lap_start;
            n_lap_start    = r_s1_now;
            n_lap_seen     = n_peaks;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_en      <= 1'b0;
            r_idle_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IDX_ENABLE:  r_idle_en      <= i_cfg_data[0];
                CFG_IDX_TIMEOUT: r_idle_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage: hold while stalled, load on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_sample <= i_sample_centiamps;
            r_s1_now    <= i_now_ms;
        end
    end

    // result valid: set on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // detector state: update only when a sample moves into the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior        <= '0;
            r_rise_run     <= '0;
            r_fall_run     <= '0;
            r_armed        <= 1'b0;
            r_peaks        <= '0;
            r_min          <= MIN_RESET;
            r_max          <= '0;
            r_level        <= FALLBACK_LEVEL;
            r_idle_seen    <= '0;
            r_idle_start   <= '0;
            r_idle_state   <= 1'b0;
            r_lap_seen     <= '0;
            r_lap_start    <= '0;
            r_lap_interval <= '0;
        end else if (w_s1_adv) begin
            r_prior        <= r_s1_sample;
            r_rise_run     <= n_rise_run;
            r_fall_run     <= n_fall_run;
            r_armed        <= n_armed;
            r_peaks        <= n_peaks;
            r_min          <= n_min;
            r_max          <= n_max;
            r_level        <= n_level;
            r_idle_seen    <= n_idle_seen;
            r_idle_start   <= n_idle_start;
            r_idle_state   <= n_idle_state;
            r_lap_seen     <= n_lap_seen;
            r_lap_start    <= n_lap_start;
            r_lap_interval <= n_lap_interval;
        end
    end

    assign w_peaks_ext        = 32'(r_peaks);
    assign o_out_valid        = r_out_valid;
    assign o_peak_total       = w_peaks_ext[15:0];
    assign o_edge_armed       = r_armed;
    assign o_idle_flag        = r_idle_state;
    assign o_peak_interval_ms = r_lap_interval;
    assign o_level_centiamps  = r_level;
    assign o_low_centiamps    = r_min;
    assign o_high_centiamps   = r_max;

    // A peak is counted only on an advance, by one, and closes an armed rise.
    a_peak_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_peaks != $past(r_peaks)) |->
            ($past(w_s1_adv) && r_peaks == $past(r_peaks) + COUNT_WIDTH'(1)
             && $past(r_armed) && !r_armed))
        else $error("peak count changed without closing an armed rise");

    // Threshold is the fallback or lies between the running min and max.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level == FALLBACK_LEVEL) || (r_level >= r_min && r_level <= r_max))
        else $error("threshold outside min/max span");

    // Stall the input only while the input stage is full and cannot advance.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room available");

    // A held result leaves the detector state untouched.
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> ($stable(r_peaks) && $stable(r_level)))
        else $error("detector state moved while result stalled");

endmodule

`default_nettype wire
